/* rtl/evd_pkg.sv */
// Shared types, widths and constants for the elliptical vignette darken unit.
`timescale 1ns / 1ps

package evd_pkg;

   localparam int COORD_BITS_DEF = 12;
   localparam int CHAN_BITS      = 8;
   localparam int CENTER_BITS    = 14;
   localparam int INV_BITS       = 20;
   localparam int STRENGTH_BITS  = 16;
   localparam int CSR_ADDR_BITS  = 3;
   localparam int CSR_DATA_BITS  = 20;

   // Axis datapath, sized for the widest coordinate (14 bits)
   localparam int DIFF_BITS  = 16;
   localparam int ABS_BITS   = 15;
   localparam int PROD_BITS  = ABS_BITS + INV_BITS;
   localparam int MAG_BITS   = 31;
   localparam int SQ_BITS    = 2 * MAG_BITS;
   localparam int SUM_BITS   = SQ_BITS + 1;

   // Square root
   localparam int ROOT_BITS  = 32;
   localparam int RAD_BITS   = 2 * ROOT_BITS;
   localparam int REM_BITS   = ROOT_BITS + 3;

   // Shading
   localparam int SHADE_BITS = STRENGTH_BITS + ROOT_BITS;
   localparam int SHADE_SHIFT = 20;
   localparam int VMAG_BITS  = 9;
   localparam int V_BITS     = VMAG_BITS + 1;
   localparam int RES_BITS   = V_BITS + 1;

   localparam logic [INV_BITS-1:0]  DEFAULT_INV_RADIUS = 20'd6554;
   localparam logic [ROOT_BITS-1:0] ONE_Q16            = 32'h0001_0000;
   localparam logic [VMAG_BITS-1:0] V_LIMIT            = 9'd256;

   typedef enum logic [CSR_ADDR_BITS-1:0] {
      REG_CENTER_COL     = 3'd0,
      REG_CENTER_ROW     = 3'd1,
      REG_INV_RADIUS_COL = 3'd2,
      REG_INV_RADIUS_ROW = 3'd3,
      REG_STRENGTH       = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic [CHAN_BITS-1:0] blue;
      logic [CHAN_BITS-1:0] green;
      logic [CHAN_BITS-1:0] red;
   } pixel_type;

   // Pipeline control handed to each stage group
   typedef struct packed {
      logic advance;
      logic valid;
   } ctl_type;

endpackage

/* rtl/evd_axis_mag.sv */
// One axis: offset from center, scale by reciprocal radius, saturate and square.
`timescale 1ns / 1ps

module evd_axis_mag #(
   parameter int COORD_BITS = evd_pkg::COORD_BITS_DEF
) (
   input  logic                                     clock,
   input  logic                                     advance,
   input  logic [COORD_BITS-1:0]                    coord,
   input  logic signed [evd_pkg::CENTER_BITS-1:0]   center,
   input  logic [evd_pkg::INV_BITS-1:0]             inv_radius,
   output logic [evd_pkg::SQ_BITS-1:0]              sq
);
   import evd_pkg::*;

   logic signed [DIFF_BITS-1:0] diff;
   logic [ABS_BITS-1:0]         abs_in, abs_ff;
   logic [INV_BITS-1:0]         inv_in, inv_ff;
   logic [PROD_BITS-1:0]        prod_ff;
   logic [MAG_BITS-1:0]         mag;
   logic [SQ_BITS-1:0]          sq_ff;

   always_comb begin
      diff   = $signed({{(DIFF_BITS-COORD_BITS){1'b0}}, coord}) - DIFF_BITS'(center);
      abs_in = diff[DIFF_BITS-1] ? ABS_BITS'(-diff) : ABS_BITS'(diff);
      inv_in = (inv_radius == '0) ? DEFAULT_INV_RADIUS : inv_radius;
      // saturate at 2^31-1, well past the point where the offset clips
      mag    = (|prod_ff[PROD_BITS-1:MAG_BITS]) ? {MAG_BITS{1'b1}} : prod_ff[MAG_BITS-1:0];
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         abs_ff  <= abs_in;
         inv_ff  <= inv_in;
         prod_ff <= PROD_BITS'(abs_ff) * PROD_BITS'(inv_ff);
         sq_ff   <= SQ_BITS'(mag) * SQ_BITS'(mag);
      end
   end

   assign sq = sq_ff;

endmodule

/* rtl/evd_sqrt_pipe.sv */
// Pipelined integer square root, one result bit per stage.
`timescale 1ns / 1ps

module evd_sqrt_pipe (
   input  logic                              clock,
   input  logic                              reset,
   input  evd_pkg::ctl_type                  ctl,
   input  logic [evd_pkg::RAD_BITS-1:0]      radicand,
   input  evd_pkg::pixel_type                pix_i,
   output logic                              valid_o,
   output logic [evd_pkg::ROOT_BITS-1:0]     root_o,
   output evd_pkg::pixel_type                pix_o
);
   import evd_pkg::*;

   logic [RAD_BITS-1:0]  rad_ff  [ROOT_BITS];
   logic [ROOT_BITS-1:0] root_ff [ROOT_BITS];
   logic [REM_BITS-1:0]  rem_ff  [ROOT_BITS];
   pixel_type            pix_ff  [ROOT_BITS];
   logic [ROOT_BITS-1:0] vld_ff;

   for (genvar k = 0; k < ROOT_BITS; k++) begin : g_stage
      logic [RAD_BITS-1:0]  rad_prev;
      logic [ROOT_BITS-1:0] root_prev;
      logic [REM_BITS-1:0]  rem_prev;
      pixel_type            pix_prev;
      logic                 vld_prev;
      logic [REM_BITS-1:0]  rem_sh;
      logic [REM_BITS-1:0]  trial;
      logic                 fits;

      if (k == 0) begin : g_first
         assign rad_prev  = radicand;
         assign root_prev = '0;
         assign rem_prev  = '0;
         assign pix_prev  = pix_i;
         assign vld_prev  = ctl.valid;
      end else begin : g_next
         assign rad_prev  = rad_ff[k-1];
         assign root_prev = root_ff[k-1];
         assign rem_prev  = rem_ff[k-1];
         assign pix_prev  = pix_ff[k-1];
         assign vld_prev  = vld_ff[k-1];
      end

      // bring down the next two radicand bits, try root*4+1
      always_comb begin
         rem_sh = {rem_prev[REM_BITS-3:0], rad_prev[RAD_BITS-1 -: 2]};
         trial  = REM_BITS'({root_prev, 2'b01});
         fits   = (rem_sh >= trial);
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (ctl.advance) begin
            vld_ff[k] <= vld_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (ctl.advance) begin
            rad_ff[k]  <= {rad_prev[RAD_BITS-3:0], 2'b00};
            root_ff[k] <= {root_prev[ROOT_BITS-2:0], fits};
            rem_ff[k]  <= fits ? (rem_sh - trial) : rem_sh;
            pix_ff[k]  <= pix_prev;
         end
      end
   end

   assign valid_o = vld_ff[ROOT_BITS-1];
   assign root_o  = root_ff[ROOT_BITS-1];
   assign pix_o   = pix_ff[ROOT_BITS-1];

endmodule

/* rtl/evd_shade.sv */
// Distance past the unit ellipse, strength scaling and per-channel subtraction.
`timescale 1ns / 1ps

module evd_shade (
   input  logic                                    clock,
   input  logic                                    reset,
   input  evd_pkg::ctl_type                        ctl,
   input  logic [evd_pkg::ROOT_BITS-1:0]           root,
   input  evd_pkg::pixel_type                      pix_i,
   input  logic signed [evd_pkg::STRENGTH_BITS-1:0] strength,
   output logic                                    valid_o,
   output evd_pkg::pixel_type                      pix_o
);
   import evd_pkg::*;

   logic [ROOT_BITS-1:0]     d_in, d_ff;
   logic [STRENGTH_BITS-1:0] smag;
   logic [SHADE_BITS-1:0]    prod_ff;
   logic [SHADE_BITS-SHADE_SHIFT-1:0] vraw;
   logic [VMAG_BITS-1:0]     vmag;
   logic signed [V_BITS-1:0] v;
   pixel_type                pix_d_ff, pix_p_ff, pix_in, pix_out_ff;
   logic [2:0]               vld_ff;

   function automatic logic [CHAN_BITS-1:0] shade_chan(
      input logic [CHAN_BITS-1:0] c,
      input logic signed [V_BITS-1:0] off
   );
      logic signed [RES_BITS-1:0] r;
      begin
         r = $signed({{(RES_BITS-CHAN_BITS){1'b0}}, c}) - RES_BITS'(off);
         if (r[RES_BITS-1]) begin
            shade_chan = '0;
         end else if (|r[RES_BITS-2:CHAN_BITS]) begin
            shade_chan = '1;
         end else begin
            shade_chan = r[CHAN_BITS-1:0];
         end
      end
   endfunction

   always_comb begin
      d_in = (root > ONE_Q16) ? (root - ONE_Q16) : '0;
      smag = strength[STRENGTH_BITS-1] ? STRENGTH_BITS'(-strength) : STRENGTH_BITS'(strength);
      vraw = prod_ff[SHADE_BITS-1:SHADE_SHIFT];
      vmag = (vraw > (SHADE_BITS-SHADE_SHIFT)'(V_LIMIT)) ? V_LIMIT : vraw[VMAG_BITS-1:0];
      // the user must keep strength quiet while items are in flight; the block does not enforce it
      v    = strength[STRENGTH_BITS-1] ? -$signed({1'b0, vmag}) : $signed({1'b0, vmag});
      pix_in.red   = shade_chan(pix_p_ff.red, v);
      pix_in.green = shade_chan(pix_p_ff.green, v);
      pix_in.blue  = shade_chan(pix_p_ff.blue, v);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (ctl.advance) begin
         vld_ff <= {vld_ff[1:0], ctl.valid};
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.advance) begin
         d_ff       <= d_in;
         pix_d_ff   <= pix_i;
         prod_ff    <= SHADE_BITS'(smag) * SHADE_BITS'(d_ff);
         pix_p_ff   <= pix_d_ff;
         pix_out_ff <= pix_in;
      end
   end

   assign valid_o = vld_ff[2];
   assign pix_o   = pix_out_ff;

endmodule

/* rtl/elliptical_vignette_darken_unit.sv */
// Top level: config registers, axis front end, square root and shading pipeline.
// Pipeline from an accepted req transaction to rsp_tvalid:
//   3 axis stages, 1 sum stage, 32 square root stages, 3 shading stages.
// Throughput: one pixel per cycle; the whole pipeline holds while rsp is stalled.
// Reset (synchronous, active high) clears all valid bits and the config registers.
`timescale 1ns / 1ps

module elliptical_vignette_darken_unit #(
   parameter int COORD_BITS = evd_pkg::COORD_BITS_DEF,
   localparam int REQ_BITS  = ((2 * COORD_BITS + 3 * evd_pkg::CHAN_BITS + 7) / 8) * 8
) (
   input  logic                               clock,
   input  logic                               reset,
   // req_tdata: col, row, red_in, green_in, blue_in (low bits up), zero pad
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [REQ_BITS-1:0]                req_tdata,
   // rsp_tdata: red_out, green_out, blue_out (low bits up)
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [3*evd_pkg::CHAN_BITS-1:0]    rsp_tdata,
   input  logic                               csr_we,
   input  logic [evd_pkg::CSR_ADDR_BITS-1:0]  csr_addr,
   input  logic [evd_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);
   import evd_pkg::*;

   localparam int PRE_STAGES = 4;

   logic signed [CENTER_BITS-1:0]   center_col_ff, center_row_ff;
   logic [INV_BITS-1:0]             inv_col_ff, inv_row_ff;
   logic signed [STRENGTH_BITS-1:0] strength_ff;

   logic                  advance;
   logic [COORD_BITS-1:0] col, row;
   pixel_type             pix_req;
   logic [SQ_BITS-1:0]    sq_x, sq_y;
   logic [SUM_BITS-1:0]   sum_ff;
   logic [PRE_STAGES-1:0] pre_vld_ff;
   pixel_type             pre_pix_ff [PRE_STAGES];
   ctl_type               sqrt_ctl, shade_ctl;
   logic                  sqrt_vld;
   logic [ROOT_BITS-1:0]  sqrt_root;
   pixel_type             sqrt_pix, pix_rsp;

   // config writes
   always_ff @(posedge clock) begin
      if (reset) begin
         center_col_ff <= '0;
         center_row_ff <= '0;
         inv_col_ff    <= '0;
         inv_row_ff    <= '0;
         strength_ff   <= '0;
      end else if (csr_we) begin
         unique case (csr_addr)
            REG_CENTER_COL:     center_col_ff <= csr_wdata[CENTER_BITS-1:0];
            REG_CENTER_ROW:     center_row_ff <= csr_wdata[CENTER_BITS-1:0];
            REG_INV_RADIUS_COL: inv_col_ff    <= csr_wdata[INV_BITS-1:0];
            REG_INV_RADIUS_ROW: inv_row_ff    <= csr_wdata[INV_BITS-1:0];
            REG_STRENGTH:       strength_ff   <= csr_wdata[STRENGTH_BITS-1:0];
            default: ;
         endcase
      end
   end

   assign advance    = !rsp_tvalid || rsp_tready;
   assign req_tready = advance;

   assign col           = req_tdata[COORD_BITS-1:0];
   assign row           = req_tdata[2*COORD_BITS-1:COORD_BITS];
   assign pix_req.red   = req_tdata[2*COORD_BITS +: CHAN_BITS];
   assign pix_req.green = req_tdata[2*COORD_BITS+CHAN_BITS +: CHAN_BITS];
   assign pix_req.blue  = req_tdata[2*COORD_BITS+2*CHAN_BITS +: CHAN_BITS];

   evd_axis_mag #(.COORD_BITS(COORD_BITS)) u_axis_col (
      .clock      (clock),
      .advance    (advance),
      .coord      (col),
      .center     (center_col_ff),
      .inv_radius (inv_col_ff),
      .sq         (sq_x)
   );

   evd_axis_mag #(.COORD_BITS(COORD_BITS)) u_axis_row (
      .clock      (clock),
      .advance    (advance),
      .coord      (row),
      .center     (center_row_ff),
      .inv_radius (inv_row_ff),
      .sq         (sq_y)
   );

   // valid and pixel ride alongside the axis stages and the sum stage
   always_ff @(posedge clock) begin
      if (reset) begin
         pre_vld_ff <= '0;
      end else if (advance) begin
         pre_vld_ff <= {pre_vld_ff[PRE_STAGES-2:0], req_tvalid};
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         pre_pix_ff[0] <= pix_req;
         for (int i = 1; i < PRE_STAGES; i++) begin
            pre_pix_ff[i] <= pre_pix_ff[i-1];
         end
         sum_ff <= SUM_BITS'(sq_x) + SUM_BITS'(sq_y);
      end
   end

   assign sqrt_ctl.advance = advance;
   assign sqrt_ctl.valid   = pre_vld_ff[PRE_STAGES-1];

   evd_sqrt_pipe u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .ctl      (sqrt_ctl),
      .radicand (RAD_BITS'(sum_ff)),
      .pix_i    (pre_pix_ff[PRE_STAGES-1]),
      .valid_o  (sqrt_vld),
      .root_o   (sqrt_root),
      .pix_o    (sqrt_pix)
   );

   assign shade_ctl.advance = advance;
   assign shade_ctl.valid   = sqrt_vld;

   evd_shade u_shade (
      .clock    (clock),
      .reset    (reset),
      .ctl      (shade_ctl),
      .root     (sqrt_root),
      .pix_i    (sqrt_pix),
      .strength (strength_ff),
      .valid_o  (rsp_tvalid),
      .pix_o    (pix_rsp)
   );

   assign rsp_tdata = {pix_rsp.blue, pix_rsp.green, pix_rsp.red};

   a_stall_only_on_backpressure: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (rsp_tvalid && !rsp_tready))
      else $error("req stalled without rsp backpressure");

   a_accept_enters_pipe: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> pre_vld_ff[0])
      else $error("accepted transaction missing from first stage");

   a_reset_empties_output: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp_tvalid set right after reset");

   a_hold_when_stalled: assert property (@(posedge clock) disable iff (reset)
      !advance |=> (pre_vld_ff == $past(pre_vld_ff)))
      else $error("front pipeline moved during stall");

endmodule
